// ----- design/dvbt_pkg.sv -----
`default_nettype none
package dvbt_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_TABLE    = 3'd1,
      MODE_UCS2     = 3'd2,
      MODE_UTF8     = 3'd3,
      MODE_SELECTOR = 3'd4,
      MODE_SINGLE   = 3'd5
   } mode_type;

   // Kind of work the back end does for one word.
   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_CHAR = 2'd1,
      ACT_COPY = 2'd2,
      ACT_HDR  = 2'd3
   } act_type;

   // One classified word handed from the front end to the back end.
   typedef struct packed {
      logic          first;
      logic          last;
      act_type       act;
      logic [15:0]   code;
      logic [7:0]    raw;
   } cmd_type;

   localparam logic [7:0]  MARKER    = 8'h15;
   localparam logic [7:0]  CODE_UCS2 = 8'h11;
   localparam logic [7:0]  CODE_SEL  = 8'h10;
   localparam logic [7:0]  LINEFEED  = 8'h8A;
   localparam logic [7:0]  CR        = 8'h0D;

   function automatic logic is_control(input logic [7:0] b);
      is_control = (b <= 8'h1F) || (b >= 8'h7F && b <= 8'h9F);
   endfunction

   function automatic logic [15:0] single_map(input logic [7:0] b);
      logic [15:0] w;
      w = 16'h0;
      case (b)
         8'hA4: w = 16'h20AC; 8'hA8: w = 16'h00A4; 8'hA9: w = 16'h2018;
         8'hAA: w = 16'h201C; 8'hAC: w = 16'h2190; 8'hAD: w = 16'h2191;
         8'hAE: w = 16'h2192; 8'hAF: w = 16'h2193; 8'hB4: w = 16'h00D7;
         8'hB8: w = 16'h00F7; 8'hB9: w = 16'h2019; 8'hBA: w = 16'h201D;
         8'hD0: w = 16'h2015; 8'hD1: w = 16'h00B9; 8'hD2: w = 16'h00AE;
         8'hD3: w = 16'h00A9; 8'hD4: w = 16'h2122; 8'hD5: w = 16'h266A;
         8'hD6: w = 16'h00AC; 8'hD7: w = 16'h00A6; 8'hDC: w = 16'h215B;
         8'hDD: w = 16'h215C; 8'hDE: w = 16'h215D; 8'hDF: w = 16'h215E;
         8'hE0: w = 16'h2126; 8'hE1: w = 16'h00C6; 8'hE2: w = 16'h0110;
         8'hE3: w = 16'h00AA; 8'hE4: w = 16'h0126; 8'hE6: w = 16'h0132;
         8'hE7: w = 16'h013F; 8'hE8: w = 16'h0141; 8'hE9: w = 16'h00D8;
         8'hEA: w = 16'h0152; 8'hEB: w = 16'h00BA; 8'hEC: w = 16'h00DE;
         8'hED: w = 16'h0166; 8'hEE: w = 16'h014A; 8'hEF: w = 16'h0149;
         8'hF0: w = 16'h0138; 8'hF1: w = 16'h00E6; 8'hF2: w = 16'h0111;
         8'hF3: w = 16'h00F0; 8'hF4: w = 16'h0127; 8'hF5: w = 16'h0131;
         8'hF6: w = 16'h0133; 8'hF7: w = 16'h0140; 8'hF8: w = 16'h0142;
         8'hF9: w = 16'h00F8; 8'hFA: w = 16'h0153; 8'hFB: w = 16'h00DF;
         8'hFC: w = 16'h00FE; 8'hFD: w = 16'h0167; 8'hFE: w = 16'h014B;
         8'hFF: w = 16'h00AD;
         default: w = {8'h00, b};
      endcase
      single_map = w;
   endfunction

   function automatic logic [15:0] combine(input logic [7:0] p, input logic [7:0] b);
      logic [15:0] w;
      w = {8'h00, b};
      case ({p, b})
         16'hC141: w = 16'hC0;  16'hC145: w = 16'hC8;  16'hC149: w = 16'hCC;
         16'hC14F: w = 16'hD2;  16'hC155: w = 16'hD9;  16'hC161: w = 16'hE0;
         16'hC165: w = 16'hE8;  16'hC169: w = 16'hEC;  16'hC16F: w = 16'hF2;
         16'hC175: w = 16'hF9;
         16'hC220: w = 16'hB4;  16'hC241: w = 16'hC1;  16'hC243: w = 16'h106;
         16'hC245: w = 16'hC9;  16'hC249: w = 16'hCD;  16'hC24C: w = 16'h139;
         16'hC24E: w = 16'h143; 16'hC24F: w = 16'hD3;  16'hC252: w = 16'h154;
         16'hC253: w = 16'h15A; 16'hC255: w = 16'hDA;  16'hC259: w = 16'hDD;
         16'hC25A: w = 16'h179; 16'hC261: w = 16'hE1;  16'hC263: w = 16'h107;
         16'hC265: w = 16'hE9;  16'hC269: w = 16'hED;  16'hC26C: w = 16'h13A;
         16'hC26E: w = 16'h144; 16'hC26F: w = 16'hF3;  16'hC272: w = 16'h155;
         16'hC273: w = 16'h15B; 16'hC275: w = 16'hFA;  16'hC279: w = 16'hFD;
         16'hC27A: w = 16'h17A;
         16'hC341: w = 16'hC2;  16'hC343: w = 16'h108; 16'hC345: w = 16'hCA;
         16'hC347: w = 16'h11C; 16'hC348: w = 16'h124; 16'hC349: w = 16'hCE;
         16'hC34A: w = 16'h134; 16'hC34F: w = 16'hD4;  16'hC353: w = 16'h15C;
         16'hC355: w = 16'hDB;  16'hC357: w = 16'h174; 16'hC359: w = 16'h176;
         16'hC361: w = 16'hE2;  16'hC363: w = 16'h109; 16'hC365: w = 16'hEA;
         16'hC367: w = 16'h11D; 16'hC368: w = 16'h125; 16'hC369: w = 16'hEE;
         16'hC36A: w = 16'h135; 16'hC36F: w = 16'hF4;  16'hC373: w = 16'h15D;
         16'hC375: w = 16'hFB;  16'hC377: w = 16'h175; 16'hC379: w = 16'h177;
         16'hC441: w = 16'hC3;  16'hC449: w = 16'h128; 16'hC44E: w = 16'hD1;
         16'hC44F: w = 16'hD5;  16'hC455: w = 16'h168; 16'hC461: w = 16'hE3;
         16'hC469: w = 16'h129; 16'hC46E: w = 16'hF1;  16'hC46F: w = 16'hF5;
         16'hC475: w = 16'h169;
         16'hC520: w = 16'hAF;  16'hC541: w = 16'h100; 16'hC545: w = 16'h112;
         16'hC549: w = 16'h12A; 16'hC54F: w = 16'h14C; 16'hC555: w = 16'h16A;
         16'hC561: w = 16'h101; 16'hC565: w = 16'h113; 16'hC569: w = 16'h12B;
         16'hC56F: w = 16'h14D; 16'hC575: w = 16'h16B;
         16'hC620: w = 16'h2D8; 16'hC641: w = 16'h102; 16'hC647: w = 16'h11E;
         16'hC655: w = 16'h16C; 16'hC661: w = 16'h103; 16'hC667: w = 16'h11F;
         16'hC675: w = 16'h16D;
         16'hC720: w = 16'h2D9; 16'hC743: w = 16'h10A; 16'hC745: w = 16'h116;
         16'hC747: w = 16'h120; 16'hC749: w = 16'h130; 16'hC75A: w = 16'h17B;
         16'hC763: w = 16'h10B; 16'hC765: w = 16'h117; 16'hC767: w = 16'h121;
         16'hC77A: w = 16'h17C;
         16'hC820: w = 16'hA8;  16'hC841: w = 16'hC4;  16'hC845: w = 16'hCB;
         16'hC849: w = 16'hCF;  16'hC84F: w = 16'hD6;  16'hC855: w = 16'hDC;
         16'hC859: w = 16'h178; 16'hC861: w = 16'hE4;  16'hC865: w = 16'hEB;
         16'hC869: w = 16'hEF;  16'hC86F: w = 16'hF6;  16'hC875: w = 16'hFC;
         16'hC879: w = 16'hFF;
         16'hCA20: w = 16'h2DA; 16'hCA41: w = 16'hC5;  16'hCA55: w = 16'h16E;
         16'hCA61: w = 16'hE5;  16'hCA75: w = 16'h16F;
         16'hCB20: w = 16'hB8;  16'hCB43: w = 16'hC7;  16'hCB47: w = 16'h122;
         16'hCB4B: w = 16'h136; 16'hCB4C: w = 16'h13B; 16'hCB4E: w = 16'h145;
         16'hCB52: w = 16'h156; 16'hCB53: w = 16'h15E; 16'hCB54: w = 16'h162;
         16'hCB63: w = 16'hE7;  16'hCB67: w = 16'h123; 16'hCB6B: w = 16'h137;
         16'hCB6C: w = 16'h13C; 16'hCB6E: w = 16'h146; 16'hCB72: w = 16'h157;
         16'hCB73: w = 16'h15F; 16'hCB74: w = 16'h163;
         16'hCD20: w = 16'h2DD; 16'hCD4F: w = 16'h150; 16'hCD55: w = 16'h170;
         16'hCD6F: w = 16'h151; 16'hCD75: w = 16'h171;
         16'hCE20: w = 16'h2DB; 16'hCE41: w = 16'h104; 16'hCE45: w = 16'h118;
         16'hCE49: w = 16'h12E; 16'hCE55: w = 16'h172; 16'hCE61: w = 16'h105;
         16'hCE65: w = 16'h119; 16'hCE69: w = 16'h12F; 16'hCE75: w = 16'h173;
         16'hCF20: w = 16'h2C7; 16'hCF43: w = 16'h10C; 16'hCF44: w = 16'h10E;
         16'hCF45: w = 16'h11A; 16'hCF4C: w = 16'h13D; 16'hCF4E: w = 16'h147;
         16'hCF52: w = 16'h158; 16'hCF53: w = 16'h160; 16'hCF54: w = 16'h164;
         16'hCF5A: w = 16'h17D; 16'hCF63: w = 16'h10D; 16'hCF64: w = 16'h10F;
         16'hCF65: w = 16'h11B; 16'hCF6C: w = 16'h13E; 16'hCF6E: w = 16'h148;
         16'hCF72: w = 16'h159; 16'hCF73: w = 16'h161; 16'hCF74: w = 16'h165;
         16'hCF7A: w = 16'h17E;
         default: w = {8'h00, b};
      endcase
      combine = w;
   endfunction

endpackage
`default_nettype wire

// ----- design/dvb_text_to_utf8_transcoder.sv -----
`default_nettype none
// DVB text string to UTF-8 transcoder.
// Input channel (req_): one string byte per word, with first/last flags.
// The first byte picks the coding; the block emits the converted string on
// the rsp_ channel, one byte per word, and a closing zero after the last
// byte (rsp_is_terminator). rsp_last_of_run marks the final byte a word made.
// Configuration: csr_write_enable loads max_output_len, capacity in bytes
// including the terminator; values above MAX_OUTPUT are clamped, and below 2
// the block takes words but produces nothing.
// Structure: a front end classifies each word and tracks the coding mode, a
// two-entry queue decouples it from the back end, which applies capacity
// limits and serializes up to five bytes through an output register.
// Throughput: one output byte per cycle while the receiver is ready; a word
// that yields more than one byte holds the back end until its last byte is
// sent, and meanwhile the queue takes further words until it is full.
// When the receiver stalls the output register holds; the queue fills and
// req_ready falls. Reset clears mode, counters and queue; capacity goes to 256.
module dvb_text_to_utf8_transcoder #(
   parameter int MAX_OUTPUT = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_write_enable,
   input  wire  [12:0] csr_max_output_len,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_in_byte,
   input  wire         req_first_of_string,
   input  wire         req_last_of_string,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_terminator,
   output logic        rsp_last_of_run
);

   localparam int CW = $clog2(MAX_OUTPUT + 1) + 1;

   logic [12:0]       max_len_ff;
   logic [CW-1:0]     cap;
   logic              enable;
   logic              f_valid, f_ready, b_valid, b_ready;
   logic              b_cmd_ready;
   dvbt_pkg::cmd_type f_cmd, b_cmd;

   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= 13'd256;
      else if (csr_write_enable) max_len_ff <= csr_max_output_len;
   end

   // Capacity clamped to MAX_OUTPUT.
   always_comb begin
      if (32'(max_len_ff) > MAX_OUTPUT) cap = CW'(MAX_OUTPUT);
      else cap = CW'(max_len_ff);
   end

   assign enable    = cap >= CW'(2);
   // Below minimum capacity words are swallowed without effect.
   assign req_ready = enable ? f_ready : 1'b1;

   dvbt_front u_front (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(req_valid), .in_ready(f_ready), .in_byte(req_in_byte),
      .in_first(req_first_of_string), .in_last(req_last_of_string),
      .cmd_valid(f_valid), .cmd_ready(b_ready), .cmd(f_cmd)
   );

   logic q_ready;
   assign b_ready = q_ready;

   dvbt_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(f_valid), .wr_ready(q_ready), .wr_data(f_cmd),
      .rd_valid(b_valid), .rd_ready(b_cmd_ready), .rd_data(b_cmd)
   );

   dvbt_back #(.CW(CW)) u_back (
      .clock(clock), .reset(reset), .cap(cap),
      .cmd_valid(b_valid), .cmd_ready(b_cmd_ready), .cmd(b_cmd),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_byte(rsp_out_byte),
      .out_term(rsp_is_terminator), .out_lor(rsp_last_of_run)
   );

`ifndef NO_ASSERTIONS
   a_term_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |-> rsp_last_of_run)
      else $error("terminator not last of run");
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |-> rsp_out_byte == 8'h00)
      else $error("terminator byte nonzero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("output changed while stalled");
`endif

endmodule
`default_nettype wire

// ----- design/dvbt_front.sv -----
`default_nettype none
// Front end: tracks the string's coding mode and turns each word into one
// command for the back end. Capacity checks stay in the back end.
module dvbt_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  enable,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire  [7:0]           in_byte,
   input  wire                  in_first,
   input  wire                  in_last,
   output logic                 cmd_valid,
   input  wire                  cmd_ready,
   output dvbt_pkg::cmd_type    cmd
);

   dvbt_pkg::mode_type mode_ff, mode_in;
   logic [7:0]         prefix_ff, prefix_in;
   logic               pend_ff, pend_in;
   logic [7:0]         high_ff, high_in;
   logic [1:0]         pos_ff, pos_in;
   logic               fire;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid && enable;
   assign fire      = in_valid && cmd_ready && enable;

   always_comb begin
      logic [15:0] w;
      logic        is_pfx;
      mode_in   = mode_ff;
      prefix_in = prefix_ff;
      pend_in   = pend_ff;
      high_in   = high_ff;
      pos_in    = pos_ff;
      cmd.first = in_first;
      cmd.last  = in_last;
      cmd.act   = dvbt_pkg::ACT_NONE;
      cmd.code  = {8'h00, in_byte};
      cmd.raw   = in_byte;
      w         = 16'h0;
      is_pfx = in_byte >= 8'hC1 && in_byte <= 8'hCF && in_byte != 8'hC9
               && in_byte != 8'hCC;
      if (in_first) begin
         pend_in = 1'b0;
         high_in = 8'h00;
         pos_in  = 2'd0;
         if (in_byte >= 8'h20) begin
            mode_in = dvbt_pkg::MODE_TABLE;
         end else if (in_byte == dvbt_pkg::CODE_UCS2) begin
            mode_in = dvbt_pkg::MODE_UCS2;
         end else if (in_byte == dvbt_pkg::MARKER) begin
            mode_in = dvbt_pkg::MODE_UTF8;
         end else if (in_byte == dvbt_pkg::CODE_SEL) begin
            mode_in = dvbt_pkg::MODE_SELECTOR;
            pos_in  = 2'd1;
         end else begin
            mode_in = dvbt_pkg::MODE_SINGLE;
         end
      end
      // Table conversion applies to the opening byte of a table string too.
      if ((in_first && in_byte >= 8'h20) ||
          (!in_first && mode_ff == dvbt_pkg::MODE_TABLE)) begin
         if (!in_first && pend_ff) begin
            pend_in  = 1'b0;
            cmd.act  = dvbt_pkg::ACT_CHAR;
            cmd.code = dvbt_pkg::combine(prefix_ff, in_byte);
         end else if (in_byte == dvbt_pkg::LINEFEED) begin
            cmd.act  = dvbt_pkg::ACT_CHAR;
            cmd.code = {8'h00, dvbt_pkg::CR};
         end else if (dvbt_pkg::is_control(in_byte)) begin
            cmd.act = dvbt_pkg::ACT_NONE;
         end else if (is_pfx) begin
            prefix_in = in_byte;
            pend_in   = 1'b1;
         end else begin
            cmd.act  = dvbt_pkg::ACT_CHAR;
            cmd.code = dvbt_pkg::single_map(in_byte);
         end
      end else if (!in_first) begin
         case (mode_ff)
            dvbt_pkg::MODE_UCS2: begin
               if (pos_ff == 2'd0) begin
                  high_in = in_byte;
                  pos_in  = 2'd1;
               end else begin
                  pos_in = 2'd0;
                  w      = {high_ff, in_byte};
                  if (w == 16'hE08A) begin
                     w = {8'h00, dvbt_pkg::CR};
                  end else if (w <= 16'h001F || (w >= 16'hE07F && w <= 16'hE09F)) begin
                     w = 16'h0;
                  end
                  if (w != 16'h0) begin
                     cmd.act  = dvbt_pkg::ACT_CHAR;
                     cmd.code = w;
                  end
               end
            end
            dvbt_pkg::MODE_UTF8: begin
               if (in_byte != 8'h00) cmd.act = dvbt_pkg::ACT_COPY;
            end
            dvbt_pkg::MODE_SELECTOR: begin
               if (pos_ff == 2'd1) begin
                  pos_in = 2'd2;
               end else begin
                  pos_in  = 2'd0;
                  mode_in = dvbt_pkg::MODE_SINGLE;
                  cmd.act = dvbt_pkg::ACT_HDR;
               end
            end
            dvbt_pkg::MODE_SINGLE: begin
               if (in_byte == dvbt_pkg::LINEFEED) begin
                  cmd.act = dvbt_pkg::ACT_COPY;
                  cmd.raw = dvbt_pkg::CR;
               end else if (!dvbt_pkg::is_control(in_byte)) begin
                  cmd.act = dvbt_pkg::ACT_COPY;
               end
            end
            default: begin
               // No string open: the word is dropped, a closing flag too.
               cmd.last = 1'b0;
            end
         endcase
      end
      if (cmd.last) begin
         mode_in = dvbt_pkg::MODE_IDLE;
         pend_in = 1'b0;
         pos_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= dvbt_pkg::MODE_IDLE;
         prefix_ff <= 8'h00;
         pend_ff   <= 1'b0;
         high_ff   <= 8'h00;
         pos_ff    <= 2'd0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         prefix_ff <= prefix_in;
         pend_ff   <= pend_in;
         high_ff   <= high_in;
         pos_ff    <= pos_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/dvbt_queue.sv -----
`default_nettype none
// Two-entry queue between front and back end.
module dvbt_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  wr_valid,
   output logic                 wr_ready,
   input  dvbt_pkg::cmd_type    wr_data,
   output logic                 rd_valid,
   input  wire                  rd_ready,
   output dvbt_pkg::cmd_type    rd_data
);

   dvbt_pkg::cmd_type slot_ff [2];
   logic              rd_ptr_ff, wr_ptr_ff;
   logic [1:0]        count_ff;
   logic              push, pop;

   assign wr_ready = count_ff != 2'd2;
   assign rd_valid = count_ff != 2'd0;
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule
`default_nettype wire

// ----- design/dvbt_back.sv -----
`default_nettype none
// Back end: applies the capacity rules and serializes one command into its
// output bytes, one byte a cycle unless stalled, through an output register.
module dvbt_back #(
   parameter int CW         = 17
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [CW-1:0]        cap,
   input  wire                  cmd_valid,
   output logic                 cmd_ready,
   input  dvbt_pkg::cmd_type    cmd,
   output logic                 out_valid,
   input  wire                  out_ready,
   output logic [7:0]           out_byte,
   output logic                 out_term,
   output logic                 out_lor
);

   logic [7:0]    buf_ff [5];
   logic [7:0]    buf_in [5];
   logic [2:0]    cnt_ff, cnt_in;
   logic [2:0]    idx_ff, idx_in;
   logic          busy_ff;
   logic [CW-1:0] written_ff, written_in;
   logic          full_ff, full_in;
   logic          take;
   logic          out_v_ff;
   logic [7:0]    out_b_ff;
   logic          out_t_ff, out_l_ff;
   logic          adv;
   logic          cmd_last_ff;

   // Output register is free when empty or being taken.
   assign adv       = !out_v_ff || out_ready;
   assign cmd_ready = !busy_ff || (adv && idx_ff + 3'd1 == cnt_ff);
   assign take      = cmd_valid && cmd_ready;
   assign out_valid = out_v_ff;
   assign out_byte  = out_b_ff;
   assign out_term  = out_t_ff;
   assign out_lor   = out_l_ff;

   always_comb begin
      logic [CW-1:0] limit;
      logic [1:0]    cl;
      logic [2:0]    n;
      limit      = cap - CW'(1);
      written_in = written_ff;
      full_in    = full_ff;
      n          = 3'd0;
      for (int i = 0; i < 5; i++) buf_in[i] = 8'h00;
      if (cmd.first) begin
         written_in = '0;
         full_in    = 1'b0;
         if (cmd.raw != dvbt_pkg::CODE_SEL) begin
            buf_in[0]  = (cmd.raw >= 8'h20 || cmd.raw == dvbt_pkg::CODE_UCS2 ||
                          cmd.raw == dvbt_pkg::MARKER) ? dvbt_pkg::MARKER : cmd.raw;
            n          = 3'd1;
            written_in = CW'(1);
         end
      end
      cl = (cmd.code < 16'h0080) ? 2'd1 : (cmd.code < 16'h0800) ? 2'd2 : 2'd3;
      case (cmd.act)
         dvbt_pkg::ACT_CHAR: begin
            if (!full_in) begin
               if (written_in + CW'(cl) >= limit) begin
                  full_in = 1'b1;
               end else begin
                  if (cl == 2'd1) begin
                     buf_in[n] = cmd.code[7:0];
                  end else if (cl == 2'd2) begin
                     buf_in[n]        = {3'b110, cmd.code[10:6]};
                     buf_in[n+3'd1]   = {2'b10, cmd.code[5:0]};
                  end else begin
                     buf_in[n]        = {4'b1110, cmd.code[15:12]};
                     buf_in[n+3'd1]   = {2'b10, cmd.code[11:6]};
                     buf_in[n+3'd2]   = {2'b10, cmd.code[5:0]};
                  end
                  n          = n + {1'b0, cl};
                  written_in = written_in + CW'(cl);
               end
            end
         end
         dvbt_pkg::ACT_COPY: begin
            if (!full_in) begin
               if (written_in >= limit) begin
                  full_in = 1'b1;
               end else begin
                  buf_in[n]  = cmd.raw;
                  n          = n + 3'd1;
                  written_in = written_in + CW'(1);
               end
            end
         end
         dvbt_pkg::ACT_HDR: begin
            if (cap >= CW'(4) && cmd.raw >= 8'h01 && cmd.raw <= 8'h0F) begin
               buf_in[0]  = dvbt_pkg::CODE_SEL;
               buf_in[1]  = 8'h20;
               buf_in[2]  = cmd.raw;
               n          = 3'd3;
               written_in = CW'(3);
            end else begin
               full_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (cmd.last) begin
         buf_in[n] = 8'h00;
         n         = n + 3'd1;
      end
      cnt_in = n;
      idx_in = 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cnt_ff     <= 3'd0;
         idx_ff     <= 3'd0;
         written_ff <= '0;
         full_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         if (busy_ff && adv) begin
            out_v_ff <= 1'b1;
            out_b_ff <= buf_ff[idx_ff];
            out_l_ff <= idx_ff + 3'd1 == cnt_ff;
            out_t_ff <= cmd_last_ff && idx_ff + 3'd1 == cnt_ff;
         end else if (adv) begin
            out_v_ff <= 1'b0;
         end
         if (take) begin
            written_ff <= written_in;
            full_ff    <= full_in;
            cnt_ff     <= cnt_in;
            idx_ff     <= idx_in;
            busy_ff    <= cnt_in != 3'd0;
         end else if (busy_ff && adv) begin
            idx_ff <= idx_ff + 3'd1;
            if (idx_ff + 3'd1 == cnt_ff) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < 5; i++) buf_ff[i] <= buf_in[i];
         cmd_last_ff <= cmd.last;
      end
   end

endmodule
`default_nettype wire

// ----- tb/tb_dvb_text_to_utf8_transcoder.sv -----
`timescale 1ns / 1ps

// Tracks the string being converted and keeps the bytes still owed by the block.
class utf8_scoreboard;
   typedef struct {
      logic [7:0] out_byte;
      logic       is_term;
      logic       last_run;
   } out_rec_type;

   out_rec_type      owed[$];
   logic [12:0]      capacity;
   dvbt_pkg::mode_type mode;
   logic [7:0]       prefix;
   bit               prefix_held;
   logic [7:0]       ucs_high;
   int               position;
   int               written;
   bit               full;
   int               errors;

   function new();
      capacity = 13'd256;
      mode = dvbt_pkg::MODE_IDLE;
      prefix = 0; prefix_held = 0; ucs_high = 0; position = 0;
      written = 0; full = 0; errors = 0;
   endfunction

   function void push(logic [7:0] b, logic t);
      out_rec_type r;
      r.out_byte = b; r.is_term = t; r.last_run = 0;
      owed.push_back(r);
   endfunction

   function bit ctrl(logic [7:0] b);
      return b <= 8'h1F || (b >= 8'h7F && b <= 8'h9F);
   endfunction

   // Code point for a plain byte of the default table; a byte with no entry maps to itself.
   function logic [15:0] glyph(logic [7:0] b);
      case (b)
         8'hA4: return 16'h20AC; 8'hA8: return 16'h00A4; 8'hA9: return 16'h2018;
         8'hAA: return 16'h201C; 8'hAC: return 16'h2190; 8'hAD: return 16'h2191;
         8'hAE: return 16'h2192; 8'hAF: return 16'h2193; 8'hB4: return 16'h00D7;
         8'hB8: return 16'h00F7; 8'hB9: return 16'h2019; 8'hBA: return 16'h201D;
         8'hD0: return 16'h2015; 8'hD1: return 16'h00B9; 8'hD2: return 16'h00AE;
         8'hD3: return 16'h00A9; 8'hD4: return 16'h2122; 8'hD5: return 16'h266A;
         8'hD6: return 16'h00AC; 8'hD7: return 16'h00A6; 8'hDC: return 16'h215B;
         8'hDD: return 16'h215C; 8'hDE: return 16'h215D; 8'hDF: return 16'h215E;
         8'hE0: return 16'h2126; 8'hE1: return 16'h00C6; 8'hE2: return 16'h0110;
         8'hE3: return 16'h00AA; 8'hE4: return 16'h0126; 8'hE6: return 16'h0132;
         8'hE7: return 16'h013F; 8'hE8: return 16'h0141; 8'hE9: return 16'h00D8;
         8'hEA: return 16'h0152; 8'hEB: return 16'h00BA; 8'hEC: return 16'h00DE;
         8'hED: return 16'h0166; 8'hEE: return 16'h014A; 8'hEF: return 16'h0149;
         8'hF0: return 16'h0138; 8'hF1: return 16'h00E6; 8'hF2: return 16'h0111;
         8'hF3: return 16'h00F0; 8'hF4: return 16'h0127; 8'hF5: return 16'h0131;
         8'hF6: return 16'h0133; 8'hF7: return 16'h0140; 8'hF8: return 16'h0142;
         8'hF9: return 16'h00F8; 8'hFA: return 16'h0153; 8'hFB: return 16'h00DF;
         8'hFC: return 16'h00FE; 8'hFD: return 16'h0167; 8'hFE: return 16'h014B;
         8'hFF: return 16'h00AD;
         default: return {8'h00, b};
      endcase
   endfunction

   // Accented letter for a diacritic followed by a base byte.
   function logic [15:0] accent(logic [7:0] p, logic [7:0] b);
      case ({p, b})
         16'hC141: return 'hC0;  16'hC145: return 'hC8;  16'hC149: return 'hCC;
         16'hC14F: return 'hD2;  16'hC155: return 'hD9;  16'hC161: return 'hE0;
         16'hC165: return 'hE8;  16'hC169: return 'hEC;  16'hC16F: return 'hF2;
         16'hC175: return 'hF9;
         16'hC220: return 'hB4;  16'hC241: return 'hC1;  16'hC243: return 'h106;
         16'hC245: return 'hC9;  16'hC249: return 'hCD;  16'hC24C: return 'h139;
         16'hC24E: return 'h143; 16'hC24F: return 'hD3;  16'hC252: return 'h154;
         16'hC253: return 'h15A; 16'hC255: return 'hDA;  16'hC259: return 'hDD;
         16'hC25A: return 'h179; 16'hC261: return 'hE1;  16'hC263: return 'h107;
         16'hC265: return 'hE9;  16'hC269: return 'hED;  16'hC26C: return 'h13A;
         16'hC26E: return 'h144; 16'hC26F: return 'hF3;  16'hC272: return 'h155;
         16'hC273: return 'h15B; 16'hC275: return 'hFA;  16'hC279: return 'hFD;
         16'hC27A: return 'h17A;
         16'hC341: return 'hC2;  16'hC343: return 'h108; 16'hC345: return 'hCA;
         16'hC347: return 'h11C; 16'hC348: return 'h124; 16'hC349: return 'hCE;
         16'hC34A: return 'h134; 16'hC34F: return 'hD4;  16'hC353: return 'h15C;
         16'hC355: return 'hDB;  16'hC357: return 'h174; 16'hC359: return 'h176;
         16'hC361: return 'hE2;  16'hC363: return 'h109; 16'hC365: return 'hEA;
         16'hC367: return 'h11D; 16'hC368: return 'h125; 16'hC369: return 'hEE;
         16'hC36A: return 'h135; 16'hC36F: return 'hF4;  16'hC373: return 'h15D;
         16'hC375: return 'hFB;  16'hC377: return 'h175; 16'hC379: return 'h177;
         16'hC441: return 'hC3;  16'hC449: return 'h128; 16'hC44E: return 'hD1;
         16'hC44F: return 'hD5;  16'hC455: return 'h168; 16'hC461: return 'hE3;
         16'hC469: return 'h129; 16'hC46E: return 'hF1;  16'hC46F: return 'hF5;
         16'hC475: return 'h169;
         16'hC520: return 'hAF;  16'hC541: return 'h100; 16'hC545: return 'h112;
         16'hC549: return 'h12A; 16'hC54F: return 'h14C; 16'hC555: return 'h16A;
         16'hC561: return 'h101; 16'hC565: return 'h113; 16'hC569: return 'h12B;
         16'hC56F: return 'h14D; 16'hC575: return 'h16B;
         16'hC620: return 'h2D8; 16'hC641: return 'h102; 16'hC647: return 'h11E;
         16'hC655: return 'h16C; 16'hC661: return 'h103; 16'hC667: return 'h11F;
         16'hC675: return 'h16D;
         16'hC720: return 'h2D9; 16'hC743: return 'h10A; 16'hC745: return 'h116;
         16'hC747: return 'h120; 16'hC749: return 'h130; 16'hC75A: return 'h17B;
         16'hC763: return 'h10B; 16'hC765: return 'h117; 16'hC767: return 'h121;
         16'hC77A: return 'h17C;
         16'hC820: return 'hA8;  16'hC841: return 'hC4;  16'hC845: return 'hCB;
         16'hC849: return 'hCF;  16'hC84F: return 'hD6;  16'hC855: return 'hDC;
         16'hC859: return 'h178; 16'hC861: return 'hE4;  16'hC865: return 'hEB;
         16'hC869: return 'hEF;  16'hC86F: return 'hF6;  16'hC875: return 'hFC;
         16'hC879: return 'hFF;
         16'hCA20: return 'h2DA; 16'hCA41: return 'hC5;  16'hCA55: return 'h16E;
         16'hCA61: return 'hE5;  16'hCA75: return 'h16F;
         16'hCB20: return 'hB8;  16'hCB43: return 'hC7;  16'hCB47: return 'h122;
         16'hCB4B: return 'h136; 16'hCB4C: return 'h13B; 16'hCB4E: return 'h145;
         16'hCB52: return 'h156; 16'hCB53: return 'h15E; 16'hCB54: return 'h162;
         16'hCB63: return 'hE7;  16'hCB67: return 'h123; 16'hCB6B: return 'h137;
         16'hCB6C: return 'h13C; 16'hCB6E: return 'h146; 16'hCB72: return 'h157;
         16'hCB73: return 'h15F; 16'hCB74: return 'h163;
         16'hCD20: return 'h2DD; 16'hCD4F: return 'h150; 16'hCD55: return 'h170;
         16'hCD6F: return 'h151; 16'hCD75: return 'h171;
         16'hCE20: return 'h2DB; 16'hCE41: return 'h104; 16'hCE45: return 'h118;
         16'hCE49: return 'h12E; 16'hCE55: return 'h172; 16'hCE61: return 'h105;
         16'hCE65: return 'h119; 16'hCE69: return 'h12F; 16'hCE75: return 'h173;
         16'hCF20: return 'h2C7; 16'hCF43: return 'h10C; 16'hCF44: return 'h10E;
         16'hCF45: return 'h11A; 16'hCF4C: return 'h13D; 16'hCF4E: return 'h147;
         16'hCF52: return 'h158; 16'hCF53: return 'h160; 16'hCF54: return 'h164;
         16'hCF5A: return 'h17D; 16'hCF63: return 'h10D; 16'hCF64: return 'h10F;
         16'hCF65: return 'h11B; 16'hCF6C: return 'h13E; 16'hCF6E: return 'h148;
         16'hCF72: return 'h159; 16'hCF73: return 'h161; 16'hCF74: return 'h165;
         16'hCF7A: return 'h17E;
         default: return {8'h00, b};
      endcase
   endfunction

   function void encode_char(logic [15:0] w, int lim);
      int len;
      len = (w < 16'h80) ? 1 : (w < 16'h800) ? 2 : 3;
      if (full) return;
      if (written + len >= lim) begin
         full = 1;
         return;
      end
      if (len == 1) begin
         push(w[7:0], 0);
      end else if (len == 2) begin
         push({3'b110, w[10:6]}, 0);
         push({2'b10, w[5:0]}, 0);
      end else begin
         push({4'b1110, w[15:12]}, 0);
         push({2'b10, w[11:6]}, 0);
         push({2'b10, w[5:0]}, 0);
      end
      written += len;
   endfunction

   function void copy_out(logic [7:0] b, int lim);
      if (full) return;
      if (written >= lim) begin
         full = 1;
         return;
      end
      push(b, 0);
      written++;
   endfunction

   function void table_char(logic [7:0] b, int lim);
      logic [15:0] w;
      if (full) return;
      if (prefix_held) begin
         prefix_held = 0;
         w = accent(prefix, b);
      end else if (b == dvbt_pkg::LINEFEED) begin
         w = {8'h00, dvbt_pkg::CR};
      end else if (ctrl(b)) begin
         return;
      end else if (b >= 8'hC1 && b <= 8'hCF && b != 8'hC9 && b != 8'hCC) begin
         prefix = b;
         prefix_held = 1;
         return;
      end else begin
         w = glyph(b);
      end
      encode_char(w, lim);
   endfunction

   // Works out the bytes that one accepted word makes the block emit.
   function void note_word(logic [7:0] b, logic first, logic last);
      int cap;
      int lim;
      int start;
      logic [15:0] w;
      logic [7:0] c;
      start = owed.size();
      cap = (capacity > 4096) ? 4096 : capacity;
      if (cap < 2) return;
      lim = cap - 1;
      if (first) begin
         prefix = 0; prefix_held = 0; ucs_high = 0; position = 0;
         written = 0; full = 0;
         if (b >= 8'h20) begin
            mode = dvbt_pkg::MODE_TABLE;
            push(dvbt_pkg::MARKER, 0);
            written = 1;
            table_char(b, lim);
         end else if (b == dvbt_pkg::CODE_UCS2 || b == dvbt_pkg::MARKER) begin
            mode = (b == dvbt_pkg::CODE_UCS2) ? dvbt_pkg::MODE_UCS2 : dvbt_pkg::MODE_UTF8;
            push(dvbt_pkg::MARKER, 0);
            written = 1;
         end else if (b == dvbt_pkg::CODE_SEL) begin
            mode = dvbt_pkg::MODE_SELECTOR;
            position = 1;
         end else begin
            mode = dvbt_pkg::MODE_SINGLE;
            push(b, 0);
            written = 1;
         end
      end else begin
         case (mode)
            dvbt_pkg::MODE_TABLE: table_char(b, lim);
            dvbt_pkg::MODE_UCS2: begin
               if (position == 0) begin
                  ucs_high = b;
                  position = 1;
               end else begin
                  position = 0;
                  w = {ucs_high, b};
                  if (w == {8'hE0, dvbt_pkg::LINEFEED}) w = {8'h00, dvbt_pkg::CR};
                  else if (w <= 16'h1F || (w >= 16'hE07F && w <= 16'hE09F)) w = 0;
                  if (w != 0) encode_char(w, lim);
               end
            end
            dvbt_pkg::MODE_UTF8: if (b != 0) copy_out(b, lim);
            dvbt_pkg::MODE_SELECTOR: begin
               if (position == 1) begin
                  position = 2;
               end else begin
                  position = 0;
                  mode = dvbt_pkg::MODE_SINGLE;
                  if (cap >= 4 && b >= 8'h01 && b <= 8'h0F) begin
                     push(dvbt_pkg::CODE_SEL, 0);
                     push(8'h20, 0);
                     push(b, 0);
                     written = 3;
                  end else begin
                     full = 1;
                  end
               end
            end
            dvbt_pkg::MODE_SINGLE: begin
               c = b;
               if (c == dvbt_pkg::LINEFEED) c = dvbt_pkg::CR;
               else if (ctrl(c)) c = 0;
               if (c != 0) copy_out(c, lim);
            end
            default: return;
         endcase
      end
      if (last) begin
         push(8'h00, 1);
         mode = dvbt_pkg::MODE_IDLE;
         prefix_held = 0;
         position = 0;
      end
      if (owed.size() > start) owed[owed.size() - 1].last_run = 1;
   endfunction

   function void check_byte(logic [7:0] b, logic t, logic lr);
      out_rec_type e;
      if (owed.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected output byte %02h term %0b last %0b", b, t, lr);
         return;
      end
      e = owed.pop_front();
      if (e.out_byte !== b || e.is_term !== t || e.last_run !== lr) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected byte %02h term %0b last %0b, got %02h %0b %0b",
                     e.out_byte, e.is_term, e.last_run, b, t, lr);
      end
   endfunction
endclass

module tb_dvb_text_to_utf8_transcoder;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [12:0] csr_max_output_len;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_first_of_string;
   logic        req_last_of_string;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_terminator;
   logic        rsp_last_of_run;

   // Random idling on both channels is active while this is set.
   bit idling;

   utf8_scoreboard sb;

   dvb_text_to_utf8_transcoder dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_max_output_len(csr_max_output_len),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .req_first_of_string(req_first_of_string),
      .req_last_of_string(req_last_of_string),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_terminator(rsp_is_terminator),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // 20 ns clock.
   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Every response word is checked against the oldest byte still owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_byte(rsp_out_byte, rsp_is_terminator, rsp_last_of_run);
   end

   // The receiver stalls in random bursts while idling is on.
   initial begin
      rsp_ready = 1;
      forever begin
         @(negedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // Presents one word and holds it until the block takes it. The prediction
   // is made at the accepting edge. A random gap may follow the word.
   task automatic send_word(input logic [7:0] b, input logic first, input logic last);
      @(negedge clock);
      req_valid <= 1;
      req_in_byte <= b;
      req_first_of_string <= first;
      req_last_of_string <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_word(b, first, last);
      if (idling && $urandom_range(0, 2) == 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(1, 11) - 1) @(negedge clock);
      end
   endtask

   // Takes the input channel idle, waits for all owed bytes, then lets the
   // pipeline settle, since words such as a held prefix leave nothing to wait for.
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [12:0] v);
      drain();
      @(negedge clock);
      csr_write_enable <= 1;
      csr_max_output_len <= v;
      @(negedge clock);
      csr_write_enable <= 0;
      sb.capacity = v;
   endtask

   // Content bytes lean toward letters and diacritics so that accents
   // combine often, with fully random bytes mixed in.
   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return $urandom_range(8'h41, 8'h7A);
      if (r < 5) return $urandom_range(8'hC1, 8'hCF);
      return $urandom_range(0, 255);
   endfunction

   // One random string: mostly well formed, sometimes with a stray word
   // outside any string or a restart in the middle.
   task automatic random_string();
      int len;
      int kind;
      logic [7:0] lead;
      len = $urandom_range(1, 10);
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: lead = $urandom_range(8'h20, 8'hFF);
         3, 4: lead = dvbt_pkg::CODE_UCS2;
         5: lead = dvbt_pkg::MARKER;
         6: lead = dvbt_pkg::CODE_SEL;
         7: lead = $urandom_range(0, 8'h1F);
         default: lead = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 9) == 0)
         send_word($urandom_range(0, 255), 0, $urandom_range(0, 1));
      send_word(lead, 1, len == 1);
      for (int i = 1; i < len; i++) begin
         if (lead == dvbt_pkg::CODE_UCS2 && i % 2 == 1 && $urandom_range(0, 1))
            send_word($urandom_range(0, 1) ? 8'h00 : 8'hE0, 0, i == len - 1);
         else if (lead == dvbt_pkg::CODE_SEL && i == 2 && $urandom_range(0, 3) != 0)
            send_word($urandom_range(1, 15), 0, i == len - 1);
         else if (i == len - 1 || $urandom_range(0, 19) != 0)
            send_word(text_byte(), 0, i == len - 1);
         else
            send_word($urandom_range(8'h20, 8'hFF), 1, 0);
      end
   endtask

   task automatic send_seq(input logic [7:0] bytes[$], input logic first_open);
      for (int i = 0; i < bytes.size(); i++)
         send_word(bytes[i], first_open && i == 0, i == bytes.size() - 1);
   endtask

   initial begin
      automatic logic [12:0] caps[$] = '{13'd2, 13'd4, 13'd0, 13'd8191, 13'd4096,
                                         13'd7, 13'd1, 13'd3, 13'd30};
      sb = new();
      idling = 1;
      reset = 1;
      csr_write_enable = 0;
      csr_max_output_len = 0;
      req_valid = 0;
      req_in_byte = 0;
      req_first_of_string = 0;
      req_last_of_string = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed strings at the reset capacity. Default table: accent,
      // three-byte euro sign, line feed, dropped control, unused prefix code,
      // and a prefix on the last byte that is dropped.
      send_seq('{8'h41, 8'hC2, 8'h65, 8'hA4, 8'h8A, 8'h05, 8'hC9, 8'hC1}, 1);
      // A prefix before zero gives a plain zero byte, not a terminator.
      send_seq('{8'h20, 8'hC8, 8'h00, 8'hFF}, 1);
      // UCS-2 with line feed, dropped control and a lone odd byte at the end.
      send_seq('{dvbt_pkg::CODE_UCS2, 8'h20, 8'hAC, 8'hE0, 8'h8A, 8'h00, 8'h05, 8'h41},
               1);
      send_seq('{dvbt_pkg::MARKER, 8'h00, 8'hFF, 8'h80}, 1);
      send_seq('{dvbt_pkg::CODE_SEL, 8'h00, 8'h05}, 1);
      send_seq('{dvbt_pkg::CODE_SEL}, 1);
      send_seq('{8'h00, 8'h8A, 8'h1F, 8'hFF}, 1);
      // A stray word with no string open, then a restart in mid string.
      send_word(8'h41, 0, 1);
      send_word(8'h41, 1, 0);
      send_seq('{8'h42}, 1);

      for (int p = 0; p < caps.size(); p++) begin
         set_capacity(caps[p]);
         random_string();
      end

      // Final stretch with no idling on either side.
      set_capacity(13'd64);
      idling = 0;
      repeat (4) random_string();

      @(negedge clock);
      req_valid <= 0;
      drain();
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("tb_dvb_text_to_utf8_transcoder passed");
      else
         $display("tb_dvb_text_to_utf8_transcoder failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_dvb_text_to_utf8_transcoder failed");
      $finish;
   end
endmodule

// ----- sim.f -----
design/dvbt_pkg.sv
design/dvbt_front.sv
design/dvbt_queue.sv
design/dvbt_back.sv
design/dvb_text_to_utf8_transcoder.sv
tb/tb_dvb_text_to_utf8_transcoder.sv
